[sv/ptrk_pkg.sv]
// Shared types, sizes and register codes for the proximity baseline tracker.
package ptrk_pkg;

  // Field and line sizes
  localparam int FREQ_BITS  = 20;
  localparam int FRAC_BITS  = 16;
  localparam int LINE_BITS  = FREQ_BITS + FRAC_BITS;
  localparam int WGT_BITS   = 16;
  localparam int HI_BITS    = LINE_BITS - WGT_BITS;
  localparam int MUL_A_BITS = (HI_BITS > FREQ_BITS) ? HI_BITS : FREQ_BITS;
  localparam int MUL_B_BITS = WGT_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int LEVEL_BITS = 8;
  localparam int SCALED_BITS = FREQ_BITS + LEVEL_BITS;
  localparam int REM_BITS   = WGT_BITS + LEVEL_BITS;

  // Stream and register port sizes
  localparam int IN_TDATA_BITS  = ((FREQ_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((LEVEL_BITS + 7) / 8) * 8;
  localparam int ADDR_BITS      = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam int REG_IDX_BITS   = 2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [MUL_B_BITS-1:0] WGT_ONE   = MUL_B_BITS'(1) << WGT_BITS;

  // Register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_FAST_WEIGHT     = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SLOW_WEIGHT     = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_NOISE_DEADZONE  = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_FULL_SCALE_DROP = 2'd3;

  // Register reset values
  localparam logic [WGT_BITS-1:0] RST_FAST_WEIGHT     = 16'd13107;
  localparam logic [WGT_BITS-1:0] RST_SLOW_WEIGHT     = 16'd65208;
  localparam logic [WGT_BITS-1:0] RST_NOISE_DEADZONE  = 16'd30;
  localparam logic [WGT_BITS-1:0] RST_FULL_SCALE_DROP = 16'd600;

  // Sequencer step counter
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] MUL_HALF  = 3'd3;
  localparam logic [STEP_BITS-1:0] MUL_LAST  = 3'd5;
  localparam logic [STEP_BITS-1:0] DIV_FIRST = 3'(LEVEL_BITS - 1);
  localparam logic [STEP_BITS-1:0] DIV_LAST  = 3'd0;

  // Product phases within one filter update
  localparam logic [STEP_BITS-1:0] PH_LO = 3'd0;
  localparam logic [STEP_BITS-1:0] PH_HI = 3'd1;
  localparam logic [STEP_BITS-1:0] PH_F  = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DROP,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WGT_BITS-1:0] fast_weight;
    logic [WGT_BITS-1:0] slow_weight;
    logic [WGT_BITS-1:0] noise_deadzone;
    logic [WGT_BITS-1:0] full_scale_drop;
  } cfg_t;

  typedef struct packed {
    logic                 load_in;
    logic                 mul_en;
    logic                 drop_en;
    logic                 scale_en;
    logic                 div_en;
    logic                 out_load;
    logic [STEP_BITS-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic first_item;
  } status_t;

endpackage

[sv/proximity_baseline_tracker.sv]
// Top level of the proximity baseline tracker.
// Counts are taken one at a time: s_tready is high only in idle, so a new count waits until
// the last result is loaded; the pace is set by six products through one shared multiplier
// and an 8-step serial divider (no products for the first count, which seeds the lines).
// A finished result waits in the output register while the next count is taken.
// Reset (rst, synchronous): registers to defaults, filter lines cleared, next count primes.
module proximity_baseline_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata fields from bit 0: freq_count[19:0], zero fill
  input  logic [ptrk_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // m_tdata fields from bit 0: pwm_level[7:0]
  output logic [ptrk_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ptrk_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [ptrk_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [ptrk_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  ptrk_pkg::cfg_t                     cfg;
  ptrk_pkg::cmd_t                     cmd;
  ptrk_pkg::status_t                  status;
  logic [ptrk_pkg::LEVEL_BITS-1:0]    level;

  assign m_tdata = ptrk_pkg::OUT_TDATA_BITS'(level);

  ptrk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptrk_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .freq_in (s_tdata[ptrk_pkg::FREQ_BITS-1:0]),
    .status  (status),
    .level   (level)
  );

endmodule

[sv/ptrk_regs.sv]
// Configuration register file behind the APB-style port.
module ptrk_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptrk_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ptrk_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [ptrk_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output ptrk_pkg::cfg_t                     cfg
);

  logic [ptrk_pkg::REG_IDX_BITS-1:0] idx;
  logic                              wr;

  assign idx    = paddr[ptrk_pkg::ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_weight     <= ptrk_pkg::RST_FAST_WEIGHT;
      cfg.slow_weight     <= ptrk_pkg::RST_SLOW_WEIGHT;
      cfg.noise_deadzone  <= ptrk_pkg::RST_NOISE_DEADZONE;
      cfg.full_scale_drop <= ptrk_pkg::RST_FULL_SCALE_DROP;
    end else if (wr) begin
      unique case (idx)
        ptrk_pkg::REG_FAST_WEIGHT:     cfg.fast_weight     <= pwdata[ptrk_pkg::WGT_BITS-1:0];
        ptrk_pkg::REG_SLOW_WEIGHT:     cfg.slow_weight     <= pwdata[ptrk_pkg::WGT_BITS-1:0];
        ptrk_pkg::REG_NOISE_DEADZONE:  cfg.noise_deadzone  <= pwdata[ptrk_pkg::WGT_BITS-1:0];
        ptrk_pkg::REG_FULL_SCALE_DROP: cfg.full_scale_drop <= pwdata[ptrk_pkg::WGT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      ptrk_pkg::REG_FAST_WEIGHT:     prdata = ptrk_pkg::CFG_DATA_BITS'(cfg.fast_weight);
      ptrk_pkg::REG_SLOW_WEIGHT:     prdata = ptrk_pkg::CFG_DATA_BITS'(cfg.slow_weight);
      ptrk_pkg::REG_NOISE_DEADZONE:  prdata = ptrk_pkg::CFG_DATA_BITS'(cfg.noise_deadzone);
      ptrk_pkg::REG_FULL_SCALE_DROP: prdata = ptrk_pkg::CFG_DATA_BITS'(cfg.full_scale_drop);
      default:                       prdata = '0;
    endcase
  end

endmodule

[sv/ptrk_dp.sv]
// Datapath: filter lines, shared multiplier, drop and dead zone, serial divider.
module ptrk_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ptrk_pkg::cfg_t                      cfg,
  input  ptrk_pkg::cmd_t                      cmd,
  input  logic [ptrk_pkg::FREQ_BITS-1:0]      freq_in,
  output ptrk_pkg::status_t                   status,
  output logic [ptrk_pkg::LEVEL_BITS-1:0]     level
);

  logic [ptrk_pkg::LINE_BITS-1:0]   fast_line;
  logic [ptrk_pkg::LINE_BITS-1:0]   slow_line;
  logic                             primed;
  logic                             first_item;
  logic [ptrk_pkg::FREQ_BITS-1:0]   freq;
  logic [ptrk_pkg::LINE_BITS-1:0]   acc;
  logic [ptrk_pkg::FREQ_BITS-1:0]   excess;
  logic [ptrk_pkg::REM_BITS-1:0]    rem;
  logic [ptrk_pkg::LEVEL_BITS-1:0]  quot;
  logic                             sat;

  logic                              sel_slow;
  logic [ptrk_pkg::STEP_BITS-1:0]    phase;
  logic [ptrk_pkg::LINE_BITS-1:0]    line;
  logic [ptrk_pkg::WGT_BITS-1:0]     wgt;
  logic [ptrk_pkg::MUL_B_BITS-1:0]   wgt_rest;
  logic [ptrk_pkg::MUL_A_BITS-1:0]   mul_a;
  logic [ptrk_pkg::MUL_B_BITS-1:0]   mul_b;
  logic [ptrk_pkg::PROD_BITS-1:0]    prod;
  logic [ptrk_pkg::PROD_BITS-1:0]    sum;
  logic [ptrk_pkg::LINE_BITS-1:0]    acc_next;

  logic [ptrk_pkg::LINE_BITS:0]      diff;
  logic [ptrk_pkg::FREQ_BITS-1:0]    drop;
  logic [ptrk_pkg::FREQ_BITS-1:0]    dz;
  logic [ptrk_pkg::FREQ_BITS-1:0]    excess_next;

  logic [ptrk_pkg::WGT_BITS-1:0]     divisor;
  logic [ptrk_pkg::SCALED_BITS-1:0]  scaled;
  logic [ptrk_pkg::SCALED_BITS-1:0]  sat_limit;
  logic [ptrk_pkg::REM_BITS-1:0]     trial;

  logic [ptrk_pkg::LEVEL_BITS-1:0] level_q;

  assign status.first_item = first_item;
  assign level = {ptrk_pkg::LEVEL_BITS{1'b0}} | level_q;

  // Select operands of the shared multiplier for this step
  always_comb begin
    sel_slow = (cmd.step >= ptrk_pkg::MUL_HALF);
    phase    = sel_slow ? (cmd.step - ptrk_pkg::MUL_HALF) : cmd.step;
    line     = sel_slow ? slow_line : fast_line;
    wgt      = sel_slow ? cfg.slow_weight : cfg.fast_weight;
    wgt_rest = ptrk_pkg::WGT_ONE - ptrk_pkg::MUL_B_BITS'(wgt);
    case (phase)
      ptrk_pkg::PH_LO: begin
        mul_a = ptrk_pkg::MUL_A_BITS'(line[ptrk_pkg::WGT_BITS-1:0]);
        mul_b = ptrk_pkg::MUL_B_BITS'(wgt);
      end
      ptrk_pkg::PH_HI: begin
        mul_a = ptrk_pkg::MUL_A_BITS'(line[ptrk_pkg::LINE_BITS-1:ptrk_pkg::WGT_BITS]);
        mul_b = ptrk_pkg::MUL_B_BITS'(wgt);
      end
      default: begin
        mul_a = ptrk_pkg::MUL_A_BITS'(freq);
        mul_b = wgt_rest;
      end
    endcase
    prod = ptrk_pkg::PROD_BITS'(mul_a) * ptrk_pkg::PROD_BITS'(mul_b);
    sum  = ptrk_pkg::PROD_BITS'(acc) + prod;
    if (phase == ptrk_pkg::PH_LO) begin
      acc_next = ptrk_pkg::LINE_BITS'(prod >> ptrk_pkg::WGT_BITS);
    end else begin
      acc_next = sum[ptrk_pkg::LINE_BITS-1:0];
    end
  end

  // Integer drop of the current line below the baseline, less the dead zone
  always_comb begin
    diff = {1'b0, slow_line} - {1'b0, fast_line};
    drop = diff[ptrk_pkg::LINE_BITS] ? '0 : diff[ptrk_pkg::LINE_BITS-1:ptrk_pkg::FRAC_BITS];
    dz   = ptrk_pkg::FREQ_BITS'(cfg.noise_deadzone);
    excess_next = (drop < dz) ? '0 : (drop - dz);
  end

  // Scale by 255 and test for saturation at the full output level
  always_comb begin
    divisor   = (cfg.full_scale_drop == '0) ? ptrk_pkg::WGT_BITS'(1) : cfg.full_scale_drop;
    scaled    = {excess, {ptrk_pkg::LEVEL_BITS{1'b0}}} - ptrk_pkg::SCALED_BITS'(excess);
    sat_limit = ptrk_pkg::SCALED_BITS'({divisor, {ptrk_pkg::LEVEL_BITS{1'b0}}});
    trial     = ptrk_pkg::REM_BITS'(divisor) << cmd.step;
  end

  // Track whether the lines hold a loaded value, seed them from the first count and update them
  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      first_item <= 1'b0;
      fast_line  <= '0;
      slow_line  <= '0;
    end else begin
      if (cmd.load_in) begin
        first_item <= !primed;
        primed     <= 1'b1;
        if (!primed) begin
          fast_line <= {freq_in, {ptrk_pkg::FRAC_BITS{1'b0}}};
          slow_line <= {freq_in, {ptrk_pkg::FRAC_BITS{1'b0}}};
        end
      end
      if (cmd.mul_en && (phase == ptrk_pkg::PH_F)) begin
        if (sel_slow) begin
          slow_line <= acc_next;
        end else begin
          fast_line <= acc_next;
        end
      end
    end
  end

  // Advance the payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      freq <= freq_in;
    end
    if (cmd.mul_en) begin
      acc <= acc_next;
    end
    if (cmd.drop_en) begin
      excess <= excess_next;
    end
    if (cmd.scale_en) begin
      sat  <= (scaled >= sat_limit);
      rem  <= scaled[ptrk_pkg::REM_BITS-1:0];
      quot <= '0;
    end
    if (cmd.div_en && (rem >= trial)) begin
      rem             <= rem - trial;
      quot[cmd.step]  <= 1'b1;
    end
    if (cmd.out_load) begin
      level_q <= sat ? ptrk_pkg::LEVEL_MAX : quot;
    end
  end

endmodule

[sv/ptrk_ctrl.sv]
// Controller: sequences the multiply, drop, scale and divide steps and the output register.
module ptrk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ptrk_pkg::status_t status,
  output ptrk_pkg::cmd_t    cmd
);

  ptrk_pkg::state_t                state;
  ptrk_pkg::state_t                state_next;
  logic [ptrk_pkg::STEP_BITS-1:0]  step;
  logic [ptrk_pkg::STEP_BITS-1:0]  step_next;
  logic                            out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ptrk_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptrk_pkg::ST_IDLE:  if (s_tvalid) state_next = ptrk_pkg::ST_MUL;
      ptrk_pkg::ST_MUL:   if (status.first_item || (step == ptrk_pkg::MUL_LAST)) begin
        state_next = ptrk_pkg::ST_DROP;
      end
      ptrk_pkg::ST_DROP:  state_next = ptrk_pkg::ST_SCALE;
      ptrk_pkg::ST_SCALE: state_next = ptrk_pkg::ST_DIV;
      ptrk_pkg::ST_DIV:   if (step == ptrk_pkg::DIV_LAST) state_next = ptrk_pkg::ST_DONE;
      ptrk_pkg::ST_DONE:  if (out_free) state_next = ptrk_pkg::ST_IDLE;
      default:            state_next = ptrk_pkg::ST_IDLE;
    endcase
  end

  // Step counter for the multiply and divide passes
  always_comb begin
    unique case (state)
      ptrk_pkg::ST_MUL:   step_next = step + 3'd1;
      ptrk_pkg::ST_SCALE: step_next = ptrk_pkg::DIV_FIRST;
      ptrk_pkg::ST_DIV:   step_next = step - 3'd1;
      default:            step_next = '0;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.step     = step;
    unique case (state)
      ptrk_pkg::ST_IDLE:  cmd.load_in  = s_tvalid;
      ptrk_pkg::ST_MUL:   cmd.mul_en   = !status.first_item;
      ptrk_pkg::ST_DROP:  cmd.drop_en  = 1'b1;
      ptrk_pkg::ST_SCALE: cmd.scale_en = 1'b1;
      ptrk_pkg::ST_DIV:   cmd.div_en   = 1'b1;
      ptrk_pkg::ST_DONE:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  // Hold state, step and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptrk_pkg::ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ptrk_pkg::ST_MUL && step == '0))
    else $error("accepted transfer did not start the multiply pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ptrk_pkg::ST_DIV && step == ptrk_pkg::DIV_LAST) |=> (state == ptrk_pkg::ST_DONE))
    else $error("divide pass did not finish");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the proximity baseline tracker stream and register ports.
`timescale 1ns / 100ps

module tb_top;
  import ptrk_pkg::*;

  localparam int HOLD_LEN = 300;   // long receiver hold-off, in cycles
  localparam int SETTLE   = 30;    // quiet cycles after the last level
  localparam int RUN_LEN  = 156;   // minimum counts per random run
  localparam int RUNS     = 12;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [ADDR_BITS-1:0]      paddr    = '0;
  logic [CFG_DATA_BITS-1:0]  pwdata   = '0;
  logic [CFG_DATA_BITS-1:0]  prdata;
  logic                      pready;

  proximity_baseline_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Counts waiting to be driven and levels waiting to come out
  logic [FREQ_BITS-1:0]  count_q[$];
  logic [LEVEL_BITS-1:0] level_q[$];

  // Predictor state: register copy, both filter lines, seed flag
  cfg_t cfg = '{fast_weight:     RST_FAST_WEIGHT,
                slow_weight:     RST_SLOW_WEIGHT,
                noise_deadzone:  RST_NOISE_DEADZONE,
                full_scale_drop: RST_FULL_SCALE_DROP};
  logic [LINE_BITS-1:0] cur_line  = '0;
  logic [LINE_BITS-1:0] base_line = '0;
  logic                 seeded    = 1'b0;

  int   errors       = 0;
  int   in_idle_max  = 19;
  int   out_idle_max = 19;
  int   hold_asks    = 0;
  int   hold_seen    = 0;
  int   out_hold     = 0;
  int   in_wait      = 0;
  int   out_wait     = 0;
  logic in_xfer      = 1'b0;
  logic out_xfer     = 1'b0;
  logic [LEVEL_BITS-1:0] want_level;

  // Q16 exponential mix: keep w/65536 of prev, take the rest from tgt
  function automatic logic [LINE_BITS-1:0] ema_step(input logic [LINE_BITS-1:0] prev,
                                                    input logic [LINE_BITS-1:0] tgt,
                                                    input logic [WGT_BITS-1:0]  w);
    logic [63:0] acc;
    acc = 64'(prev) * 64'(w) + 64'(tgt) * (64'd65536 - 64'(w));
    return LINE_BITS'(acc >> WGT_BITS);
  endfunction

  // Advance both lines by one count and return the level it yields
  function automatic logic [LEVEL_BITS-1:0] level_for_count(input logic [FREQ_BITS-1:0] cnt);
    logic [LINE_BITS-1:0] tgt;
    logic [FREQ_BITS-1:0] drop;
    logic [FREQ_BITS-1:0] net_drop;
    logic [63:0]          divisor;
    logic [63:0]          scaled;
    tgt = {cnt, FRAC_BITS'(0)};
    if (!seeded) begin
      cur_line  = tgt;
      base_line = tgt;
      seeded    = 1'b1;
    end else begin
      cur_line  = ema_step(cur_line, tgt, cfg.fast_weight);
      base_line = ema_step(base_line, tgt, cfg.slow_weight);
    end
    drop = (base_line > cur_line) ? FREQ_BITS'((base_line - cur_line) >> FRAC_BITS) : '0;
    net_drop = (drop < cfg.noise_deadzone) ? '0 : drop - cfg.noise_deadzone;
    // a zero full scale acts as one
    divisor = (cfg.full_scale_drop == '0) ? 64'd1 : 64'(cfg.full_scale_drop);
    scaled = (64'(net_drop) * 64'd255) / divisor;
    return (scaled > 64'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_BITS-1:0];
  endfunction

  function automatic logic [FREQ_BITS-1:0] clamp_freq(input longint v);
    if (v < 0) return '0;
    if (v > FREQ_MAX) return FREQ_MAX;
    return FREQ_BITS'(v);
  endfunction

  // Pick a register value: half the time a typical range, else an extreme or anything
  function automatic logic [WGT_BITS-1:0] pick_setting(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WGT_BITS'($urandom);
      default: return WGT_BITS'($urandom_range(hi, lo));
    endcase
  endfunction

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("proximity_baseline_tracker regression: fail");
    $finish;
  end

  // Sample handshakes, check levels, predict accepted counts
  always @(posedge clk) begin
    if (rst) begin
      in_xfer  <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer  <= s_tvalid && s_tready;
      out_xfer <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        if (level_q.size() == 0) begin
          $error("pwm_level: no level expected, got %0d", m_tdata[LEVEL_BITS-1:0]);
          errors++;
        end else begin
          want_level = level_q.pop_front();
          if (m_tdata[LEVEL_BITS-1:0] !== want_level) begin
            $error("pwm_level: expected %0d, got %0d", want_level, m_tdata[LEVEL_BITS-1:0]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) level_q.push_back(level_for_count(s_tdata[FREQ_BITS-1:0]));
    end
  end

  // Drive counts from the queue, with a random gap after each transfer
  always @(negedge clk) begin
    if (!rst && (in_xfer || !s_tvalid)) begin
      if (in_xfer) in_wait = $urandom_range(0, in_idle_max);
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (count_q.size() != 0) begin
        s_tdata  <= IN_TDATA_BITS'(count_q.pop_front());
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Accept levels with a random stall per level and an occasional long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        out_hold  = HOLD_LEN;
      end
      if (out_xfer) out_wait = $urandom_range(0, out_idle_max);
      if (out_hold > 0) begin
        out_hold--;
        m_tready <= 1'b0;
      end else if (out_wait > 0) begin
        if (m_tvalid) out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Wait until every count is sent and every level has come back
  task automatic wait_drained();
    while (count_q.size() != 0 || s_tvalid || level_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [WGT_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FAST_WEIGHT:     cfg.fast_weight     = value;
      REG_SLOW_WEIGHT:     cfg.slow_weight     = value;
      REG_NOISE_DEADZONE:  cfg.noise_deadzone  = value;
      REG_FULL_SCALE_DROP: cfg.full_scale_drop = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_setup(input logic [WGT_BITS-1:0] fw, input logic [WGT_BITS-1:0] sw,
                            input logic [WGT_BITS-1:0] dz, input logic [WGT_BITS-1:0] fs);
    wait_drained();
    write_reg(REG_FAST_WEIGHT, fw);
    write_reg(REG_SLOW_WEIGHT, sw);
    write_reg(REG_NOISE_DEADZONE, dz);
    write_reg(REG_FULL_SCALE_DROP, fs);
  endtask

  // Queue a run of sensor-like counts: steady stretches, hand dips, jumps, noise
  task automatic push_run(input int n);
    int k;
    int len;
    int span;
    longint base;
    longint depth;
    k    = 0;
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(FREQ_MAX, 0)
                                       : $urandom_range(400000, 20000);
    span = int'(cfg.noise_deadzone) + 2 * (int'(cfg.full_scale_drop) + 1);
    while (k < n) begin
      case ($urandom_range(0, 9))
        0: begin
          count_q.push_back(FREQ_BITS'($urandom));
          k++;
        end
        1: begin
          base = $urandom_range(FREQ_MAX, 0);
          count_q.push_back(clamp_freq(base));
          k++;
        end
        2, 3, 4: begin
          len = $urandom_range(10, 1);
          repeat (len) count_q.push_back(clamp_freq(base + $urandom_range(8, 0) - 4));
          k += len;
        end
        default: begin
          depth = $urandom_range(span, 0);
          len   = $urandom_range(16, 2);
          repeat (len) count_q.push_back(clamp_freq(base - depth + $urandom_range(4, 0) - 2));
          k += len;
        end
      endcase
    end
  endtask

  // Stimulus
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: seed on the first count, steady, a dip, count extremes
    count_q.push_back(20'd100000); count_q.push_back(20'd100000);
    count_q.push_back(20'd100000); count_q.push_back(20'd98000);
    count_q.push_back(20'd96000);  count_q.push_back(20'd0);
    count_q.push_back(20'd0);      count_q.push_back(FREQ_MAX); count_q.push_back(FREQ_MAX);
    count_q.push_back(20'h55555); count_q.push_back(20'hAAAAA);

    // Current line follows the count, baseline nearly frozen, zero full scale
    load_setup('0, '1, '0, '0);
    count_q.push_back(20'd500000); count_q.push_back(20'd500000);
    count_q.push_back(20'd499999); count_q.push_back(20'd400000);
    count_q.push_back(FREQ_MAX);

    // Sluggish current line, baseline follows, dead zone and full scale at top
    load_setup('1, '0, '1, '1);
    count_q.push_back(20'd0); count_q.push_back(20'd300000); count_q.push_back(20'd300000);
    count_q.push_back(FREQ_MAX);

    // No dead zone, smallest full scale
    load_setup(16'h8000, 16'hFFF0, '0, 16'd1);
    count_q.push_back(20'd200000); count_q.push_back(20'd199990);
    count_q.push_back(20'd100000); count_q.push_back(20'd150000);
    count_q.push_back(FREQ_MAX);

    // Random runs, each under its own register setting and idle pattern
    for (int r = 0; r < RUNS; r++) begin
      load_setup(pick_setting(0, 40000), pick_setting(60000, 65535),
                 pick_setting(0, 100), pick_setting(1, 1500));
      in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 19;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      if (r == 2 || r == 7) begin
        // hold the receiver off while the sender keeps offering counts
        in_idle_max = 0;
        @(posedge clk);
        hold_asks++;
      end
      push_run(RUN_LEN);
    end

    wait_drained();
    if (errors == 0) begin
      $display("proximity_baseline_tracker regression: pass");
    end else begin
      $display("proximity_baseline_tracker regression: fail");
    end
    $finish;
  end

endmodule
